// ----- rtl/core/pwtp_pkg.sv -----
// Shared types and codes for the protobuf wire token parser.
package pwtp_pkg;

    // decoder phases
    localparam logic [2:0] PH_KEY     = 3'd0;
    localparam logic [2:0] PH_VARINT  = 3'd1;
    localparam logic [2:0] PH_FIXED   = 3'd2;
    localparam logic [2:0] PH_LEN     = 3'd3;
    localparam logic [2:0] PH_PAYLOAD = 3'd4;

    // result kinds
    localparam logic [2:0] KIND_SCALAR = 3'd0;
    localparam logic [2:0] KIND_HEADER = 3'd1;
    localparam logic [2:0] KIND_DATA   = 3'd2;
    localparam logic [2:0] KIND_END    = 3'd3;
    localparam logic [2:0] KIND_ERROR  = 3'd4;

    // error codes
    localparam logic [1:0] ERR_NONE     = 2'd0;
    localparam logic [1:0] ERR_OVERFLOW = 2'd1;
    localparam logic [1:0] ERR_WIRE     = 2'd2;
    localparam logic [1:0] ERR_TRUNC    = 2'd3;

    // wire types
    localparam logic [2:0] WT_VARINT  = 3'd0;
    localparam logic [2:0] WT_FIXED64 = 3'd1;
    localparam logic [2:0] WT_LEN     = 3'd2;
    localparam logic [2:0] WT_FIXED32 = 3'd5;

    // shift limits and steps
    localparam logic [6:0] KEY_SHIFT_MAX   = 7'd28;
    localparam logic [6:0] VAR_SHIFT_MAX   = 7'd63;
    localparam logic [6:0] FIXED_SHIFT_MAX = 7'd56;
    localparam logic [6:0] VAR_STEP        = 7'd7;
    localparam logic [6:0] FIXED_STEP      = 7'd8;
    localparam logic [3:0] FIXED64_BYTES   = 4'd8;
    localparam logic [3:0] FIXED32_BYTES   = 4'd4;

    typedef struct packed {
        logic [2:0]  phase;
        logic [63:0] acc;
        logic [6:0]  shift_pos;
        logic [3:0]  fixed_count;
        logic [31:0] payload_left;
        logic [28:0] held_tag;
        logic [2:0]  held_wire;
        logic        dropping;
    } state_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [28:0] field_tag;
        logic [2:0]  wire_kind;
        logic [63:0] raw_value;
        logic [63:0] zigzag_value;
        logic [7:0]  data_byte;
        logic        payload_last;
        logic        msg_end;
        logic [1:0]  error_code;
    } result_t;

endpackage

// ----- rtl/core/pwtp_decode.sv -----
// One-byte decode step: next parser state and the optional result.
module pwtp_decode (
    input  pwtp_pkg::state_t  cur,
    input  logic [7:0]        in_byte,
    input  logic              is_last,
    output pwtp_pkg::state_t  nxt,
    output logic              res_valid,
    output pwtp_pkg::result_t res
);
    import pwtp_pkg::*;

    logic        more;
    logic [6:0]  sp;
    logic [63:0] acc_new;
    logic [31:0] v32;
    logic [3:0]  fc_dec;
    logic [31:0] pl_dec;
    logic        fail;
    logic [1:0]  fail_code;
    logic [28:0] fail_tag;
    logic [2:0]  fail_wire;
    logic        done;

    assign more = in_byte[7];

    always_comb
    begin
        nxt       = cur;
        res_valid = 1'b0;
        res       = '0;
        fail      = 1'b0;
        fail_code = ERR_NONE;
        fail_tag  = '0;
        fail_wire = '0;
        done      = 1'b0;
        sp        = cur.shift_pos;
        acc_new   = cur.acc;
        v32       = '0;
        fc_dec    = '0;
        pl_dec    = '0;

        if (cur.dropping)
        begin
            if (is_last)
                nxt = '0;
        end
        else
        begin
            case (cur.phase)
                PH_KEY, PH_LEN:
                begin
                    sp      = (cur.shift_pos > KEY_SHIFT_MAX) ? KEY_SHIFT_MAX : cur.shift_pos;
                    acc_new = cur.acc | ({57'd0, in_byte[6:0]} << sp[4:0]);
                    v32     = acc_new[31:0];
                    if (cur.phase == PH_LEN)
                    begin
                        fail_tag  = cur.held_tag;
                        fail_wire = cur.held_wire;
                    end
                    if (more)
                    begin
                        if (sp >= KEY_SHIFT_MAX)
                        begin
                            fail      = 1'b1;
                            fail_code = ERR_OVERFLOW;
                        end
                        else if (is_last)
                        begin
                            fail      = 1'b1;
                            fail_code = ERR_TRUNC;
                        end
                        else
                        begin
                            nxt.acc       = acc_new;
                            nxt.shift_pos = sp + VAR_STEP;
                        end
                    end
                    else if (cur.phase == PH_KEY)
                    begin
                        if (v32 == 32'd0)
                        begin
                            // zero key closes the message early
                            res_valid    = 1'b1;
                            res.kind     = KIND_END;
                            res.msg_end  = 1'b1;
                            nxt          = '0;
                            nxt.dropping = !is_last;
                        end
                        else
                        begin
                            nxt.acc       = '0;
                            nxt.shift_pos = '0;
                            nxt.held_tag  = v32[31:3];
                            nxt.held_wire = v32[2:0];
                            fail_tag      = v32[31:3];
                            fail_wire     = v32[2:0];
                            case (v32[2:0])
                                WT_VARINT:  nxt.phase = PH_VARINT;
                                WT_FIXED64:
                                begin
                                    nxt.phase       = PH_FIXED;
                                    nxt.fixed_count = FIXED64_BYTES;
                                end
                                WT_FIXED32:
                                begin
                                    nxt.phase       = PH_FIXED;
                                    nxt.fixed_count = FIXED32_BYTES;
                                end
                                WT_LEN:     nxt.phase = PH_LEN;
                                default:
                                begin
                                    fail      = 1'b1;
                                    fail_code = ERR_WIRE;
                                end
                            endcase
                            if (!fail && is_last)
                            begin
                                fail      = 1'b1;
                                fail_code = ERR_TRUNC;
                            end
                        end
                    end
                    else
                    begin
                        if (v32 == 32'd0)
                        begin
                            res_valid     = 1'b1;
                            res.kind      = KIND_HEADER;
                            res.field_tag = cur.held_tag;
                            res.wire_kind = cur.held_wire;
                            res.msg_end   = is_last;
                            done          = 1'b1;
                        end
                        else if (is_last)
                        begin
                            fail      = 1'b1;
                            fail_code = ERR_TRUNC;
                        end
                        else
                        begin
                            res_valid        = 1'b1;
                            res.kind         = KIND_HEADER;
                            res.field_tag    = cur.held_tag;
                            res.wire_kind    = cur.held_wire;
                            res.raw_value    = {32'd0, v32};
                            nxt.acc          = '0;
                            nxt.shift_pos    = '0;
                            nxt.payload_left = v32;
                            nxt.phase        = PH_PAYLOAD;
                        end
                    end
                end
                PH_VARINT:
                begin
                    sp        = (cur.shift_pos > VAR_SHIFT_MAX) ? VAR_SHIFT_MAX : cur.shift_pos;
                    acc_new   = cur.acc | ({57'd0, in_byte[6:0]} << sp[5:0]);
                    fail_tag  = cur.held_tag;
                    fail_wire = cur.held_wire;
                    if (more)
                    begin
                        if (sp >= VAR_SHIFT_MAX)
                        begin
                            fail      = 1'b1;
                            fail_code = ERR_OVERFLOW;
                        end
                        else if (is_last)
                        begin
                            fail      = 1'b1;
                            fail_code = ERR_TRUNC;
                        end
                        else
                        begin
                            nxt.acc       = acc_new;
                            nxt.shift_pos = sp + VAR_STEP;
                        end
                    end
                    else
                    begin
                        res_valid        = 1'b1;
                        res.kind         = KIND_SCALAR;
                        res.field_tag    = cur.held_tag;
                        res.wire_kind    = cur.held_wire;
                        res.raw_value    = acc_new;
                        res.zigzag_value = {1'b0, acc_new[63:1]} ^ {64{acc_new[0]}};
                        res.msg_end      = is_last;
                        done             = 1'b1;
                    end
                end
                PH_FIXED:
                begin
                    sp        = (cur.shift_pos > FIXED_SHIFT_MAX) ? FIXED_SHIFT_MAX
                                                                   : cur.shift_pos;
                    acc_new   = cur.acc | ({56'd0, in_byte} << sp[5:0]);
                    fc_dec    = (cur.fixed_count != 4'd0) ? cur.fixed_count - 4'd1 : 4'd0;
                    fail_tag  = cur.held_tag;
                    fail_wire = cur.held_wire;
                    if (fc_dec == 4'd0)
                    begin
                        res_valid     = 1'b1;
                        res.kind      = KIND_SCALAR;
                        res.field_tag = cur.held_tag;
                        res.wire_kind = cur.held_wire;
                        res.raw_value = acc_new;
                        res.msg_end   = is_last;
                        done          = 1'b1;
                    end
                    else if (is_last)
                    begin
                        fail      = 1'b1;
                        fail_code = ERR_TRUNC;
                    end
                    else
                    begin
                        nxt.acc         = acc_new;
                        nxt.shift_pos   = sp + FIXED_STEP;
                        nxt.fixed_count = fc_dec;
                    end
                end
                PH_PAYLOAD:
                begin
                    pl_dec    = (cur.payload_left != 32'd0) ? cur.payload_left - 32'd1 : 32'd0;
                    fail_tag  = cur.held_tag;
                    fail_wire = cur.held_wire;
                    if (pl_dec == 32'd0)
                    begin
                        res_valid        = 1'b1;
                        res.kind         = KIND_DATA;
                        res.field_tag    = cur.held_tag;
                        res.wire_kind    = cur.held_wire;
                        res.data_byte    = in_byte;
                        res.payload_last = 1'b1;
                        res.msg_end      = is_last;
                        done             = 1'b1;
                    end
                    else if (is_last)
                    begin
                        fail      = 1'b1;
                        fail_code = ERR_TRUNC;
                    end
                    else
                    begin
                        res_valid        = 1'b1;
                        res.kind         = KIND_DATA;
                        res.field_tag    = cur.held_tag;
                        res.wire_kind    = cur.held_wire;
                        res.data_byte    = in_byte;
                        nxt.payload_left = pl_dec;
                    end
                end
                default:
                begin
                    nxt = '0;
                end
            endcase

            // field finished: back to the key, or full clear on the final word
            if (done)
            begin
                if (is_last)
                    nxt = '0;
                else
                begin
                    nxt.phase        = PH_KEY;
                    nxt.acc          = '0;
                    nxt.shift_pos    = '0;
                    nxt.fixed_count  = '0;
                    nxt.payload_left = '0;
                end
            end

            if (fail)
            begin
                res_valid      = 1'b1;
                res            = '0;
                res.kind       = KIND_ERROR;
                res.field_tag  = fail_tag;
                res.wire_kind  = fail_wire;
                res.msg_end    = is_last;
                res.error_code = fail_code;
                nxt            = '0;
                nxt.dropping   = !is_last;
            end
        end
    end

endmodule

// ----- rtl/core/protobuf_wire_token_parser.sv -----
// Top level of the protobuf wire token parser: input register, decode, result register.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one message byte per word in
//   in_byte, with is_last set on the final byte of each message.
//   Output channel (out_valid / out_stall) carries at most one result word per
//   input word: scalar field, length header, payload byte, end or error.
//   Pipeline: an accepted word is held in the input register, decoded from
//   it by combinational logic, and its result is loaded into the result
//   register, which drives out_valid.
//   Throughput: one word per cycle while out_stall holds no result; the
//   decode state (phase, accumulator, counters) is updated by a single step
//   of combinational logic per decoded word. When out_stall holds a result,
//   the decode stage stops; an empty input register still takes one more
//   word, after which in_stall rises until the result is taken.
//   Reset (rst_n low, asynchronous) empties both registers and returns the
//   decoder to waiting for a key with no message in progress.
module protobuf_wire_token_parser (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  in_byte,
    input  logic        is_last,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  kind,
    output logic [28:0] field_tag,
    output logic [2:0]  wire_kind,
    output logic [63:0] raw_value,
    output logic signed [63:0] zigzag_value,
    output logic [7:0]  data_byte,
    output logic        payload_last,
    output logic        msg_end,
    output logic [1:0]  error_code
);
    import pwtp_pkg::*;

    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;
    logic        is_last_reg;
    state_t      state_reg;
    state_t      state_next;
    logic        out_valid_reg;
    result_t     res_reg;
    result_t     step_res;
    logic        step_valid;
    logic        advance;
    logic        take_in;

    // decode stage moves when the result register is free or being emptied
    assign advance  = !out_valid_reg || !out_stall;
    assign in_stall = in_valid_reg && !advance;
    assign take_in  = in_valid && !in_stall;

    pwtp_decode u_decode (
        .cur       (state_reg),
        .in_byte   (in_byte_reg),
        .is_last   (is_last_reg),
        .nxt       (state_next),
        .res_valid (step_valid),
        .res       (step_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            state_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (take_in)
                in_valid_reg <= 1'b1;
            else if (advance)
                in_valid_reg <= 1'b0;
            if (advance)
            begin
                out_valid_reg <= in_valid_reg && step_valid;
                if (in_valid_reg)
                    state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_in)
        begin
            in_byte_reg <= in_byte;
            is_last_reg <= is_last;
        end
        if (advance && in_valid_reg && step_valid)
            res_reg <= step_res;
    end

    assign out_valid    = out_valid_reg;
    assign kind         = res_reg.kind;
    assign field_tag    = res_reg.field_tag;
    assign wire_kind    = res_reg.wire_kind;
    assign raw_value    = res_reg.raw_value;
    assign zigzag_value = res_reg.zigzag_value;
    assign data_byte    = res_reg.data_byte;
    assign payload_last = res_reg.payload_last;
    assign msg_end      = res_reg.msg_end;
    assign error_code   = res_reg.error_code;

    a_drop_silent: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.dropping |-> !step_valid)
        else $error("result produced while dropping");

    a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && advance && is_last_reg |=> state_reg == '0)
        else $error("state not cleared after final word");

    a_end_closes: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == KIND_END |-> msg_end)
        else $error("end result without msg_end");

    a_err_kind: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && error_code != ERR_NONE |-> kind == KIND_ERROR)
        else $error("error code on a non-error result");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid_reg && out_stall && in_valid_reg)
        else $error("input stalled with free result register");

endmodule

// ----- verif/testbench.sv -----
// Self-checking testbench for the protobuf wire token parser: byte stream in, token words out.
`timescale 1ns / 1ps

module testbench;
    import pwtp_pkg::*;

    localparam int RANDOM_WORDS = 1125;
    localparam int HOLD_CYCLES  = 80;
    localparam int DRAIN_CYCLES = 8;

    typedef struct {
        logic [7:0]  b;
        logic        last;
        bit          pin;
        logic [2:0]  kind;
        logic [63:0] raw;
        logic [1:0]  err;
        logic        fin;
    } stim_row_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [7:0]  in_byte;
    logic        is_last;
    logic        out_valid;
    logic        out_stall;
    logic [2:0]  kind;
    logic [28:0] field_tag;
    logic [2:0]  wire_kind;
    logic [63:0] raw_value;
    logic signed [63:0] zigzag_value;
    logic [7:0]  data_byte;
    logic        payload_last;
    logic        msg_end;
    logic [1:0]  error_code;

    // decoder mirror
    logic [2:0]  dec_phase;
    logic [63:0] dec_acc;
    logic [6:0]  dec_shift;
    logic [3:0]  dec_fixed_left;
    logic [31:0] dec_pay_left;
    logic [28:0] dec_tag;
    logic [2:0]  dec_wire;
    logic        dec_drop;

    result_t     pending_tokens[$];
    stim_row_t   stim_rows[$];
    logic [7:0]  msg_bytes[$];

    // typed expectation for the directed row on the bus
    bit          pin_on;
    logic [2:0]  pin_kind;
    logic [63:0] pin_raw;
    logic [1:0]  pin_err;
    logic        pin_end;

    int send_idle_pct;
    int stall_pct;
    bit hold_request;
    int hold_count;
    int words_sent;
    int msgs_sent;
    int mismatch_count;
    int kind_seen[5];

    protobuf_wire_token_parser u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .in_byte      (in_byte),
        .is_last      (is_last),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .kind         (kind),
        .field_tag    (field_tag),
        .wire_kind    (wire_kind),
        .raw_value    (raw_value),
        .zigzag_value (zigzag_value),
        .data_byte    (data_byte),
        .payload_last (payload_last),
        .msg_end      (msg_end),
        .error_code   (error_code)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic result_t make_result(input logic [2:0] k, input logic [28:0] tag,
            input logic [2:0] wt, input logic [63:0] raw, input logic [63:0] zz,
            input logic [7:0] data, input logic plast, input logic fin, input logic [1:0] err);
        result_t r;
        r.kind         = k;
        r.field_tag    = tag;
        r.wire_kind    = wt;
        r.raw_value    = raw;
        r.zigzag_value = zz;
        r.data_byte    = data;
        r.payload_last = plast;
        r.msg_end      = fin;
        r.error_code   = err;
        return r;
    endfunction

    function automatic void clear_decoder();
        dec_phase      = PH_KEY;
        dec_acc        = '0;
        dec_shift      = '0;
        dec_fixed_left = '0;
        dec_pay_left   = '0;
        dec_tag        = '0;
        dec_wire       = '0;
        dec_drop       = 1'b0;
    endfunction

    function automatic void next_field(input logic last);
        if (last)
        begin
            clear_decoder();
        end
        else
        begin
            dec_phase      = PH_KEY;
            dec_acc        = '0;
            dec_shift      = '0;
            dec_fixed_left = '0;
            dec_pay_left   = '0;
        end
    endfunction

    // error word; the rest of the message is skipped unless this byte ends it
    function automatic result_t error_token(input logic [1:0] code, input logic [28:0] tag,
            input logic [2:0] wt, input logic last);
        clear_decoder();
        dec_drop = !last;
        return make_result(KIND_ERROR, tag, wt, '0, '0, '0, 1'b0, last, code);
    endfunction

    // one byte through the decoder; returns 1 when it yields a token word
    function automatic bit decode_byte(input logic [7:0] b, input logic last,
            output result_t r);
        logic [31:0] v32;
        logic [63:0] v;
        logic [28:0] etag;
        logic [2:0]  ewt;
        r = '0;
        if (dec_drop)
        begin
            if (last)
                clear_decoder();
            return 1'b0;
        end
        case (dec_phase)
            PH_KEY, PH_LEN:
            begin
                // errors on a continued key byte carry no tag yet
                etag = (dec_phase == PH_KEY) ? '0 : dec_tag;
                ewt  = (dec_phase == PH_KEY) ? '0 : dec_wire;
                if (dec_shift > KEY_SHIFT_MAX)
                    dec_shift = KEY_SHIFT_MAX;
                dec_acc |= {57'd0, b[6:0]} << dec_shift;
                if (b[7])
                begin
                    if (dec_shift >= KEY_SHIFT_MAX)
                    begin
                        r = error_token(ERR_OVERFLOW, etag, ewt, last);
                        return 1'b1;
                    end
                    if (last)
                    begin
                        r = error_token(ERR_TRUNC, etag, ewt, last);
                        return 1'b1;
                    end
                    dec_shift += VAR_STEP;
                    return 1'b0;
                end
                v32       = dec_acc[31:0];
                dec_acc   = '0;
                dec_shift = '0;
                if (dec_phase == PH_KEY)
                begin
                    if (v32 == 32'd0)
                    begin
                        r = make_result(KIND_END, '0, '0, '0, '0, '0, 1'b0, 1'b1, ERR_NONE);
                        clear_decoder();
                        dec_drop = !last;
                        return 1'b1;
                    end
                    dec_tag  = v32[31:3];
                    dec_wire = v32[2:0];
                    case (dec_wire)
                        WT_VARINT:  dec_phase = PH_VARINT;
                        WT_LEN:     dec_phase = PH_LEN;
                        WT_FIXED64:
                        begin
                            dec_phase      = PH_FIXED;
                            dec_fixed_left = FIXED64_BYTES;
                        end
                        WT_FIXED32:
                        begin
                            dec_phase      = PH_FIXED;
                            dec_fixed_left = FIXED32_BYTES;
                        end
                        default:
                        begin
                            r = error_token(ERR_WIRE, dec_tag, dec_wire, last);
                            return 1'b1;
                        end
                    endcase
                    if (last)
                    begin
                        r = error_token(ERR_TRUNC, dec_tag, dec_wire, last);
                        return 1'b1;
                    end
                    return 1'b0;
                end
                if (v32 == 32'd0)
                begin
                    r = make_result(KIND_HEADER, dec_tag, dec_wire, '0, '0, '0, 1'b0, last,
                                    ERR_NONE);
                    next_field(last);
                    return 1'b1;
                end
                if (last)
                begin
                    r = error_token(ERR_TRUNC, dec_tag, dec_wire, last);
                    return 1'b1;
                end
                r = make_result(KIND_HEADER, dec_tag, dec_wire, {32'd0, v32}, '0, '0, 1'b0,
                                1'b0, ERR_NONE);
                dec_pay_left = v32;
                dec_phase    = PH_PAYLOAD;
                return 1'b1;
            end
            PH_VARINT:
            begin
                if (dec_shift > VAR_SHIFT_MAX)
                    dec_shift = VAR_SHIFT_MAX;
                dec_acc |= {57'd0, b[6:0]} << dec_shift;
                if (b[7])
                begin
                    if (dec_shift >= VAR_SHIFT_MAX)
                    begin
                        r = error_token(ERR_OVERFLOW, dec_tag, dec_wire, last);
                        return 1'b1;
                    end
                    if (last)
                    begin
                        r = error_token(ERR_TRUNC, dec_tag, dec_wire, last);
                        return 1'b1;
                    end
                    dec_shift += VAR_STEP;
                    return 1'b0;
                end
                v = dec_acc;
                r = make_result(KIND_SCALAR, dec_tag, dec_wire, v, (v >> 1) ^ {64{v[0]}},
                                '0, 1'b0, last, ERR_NONE);
                next_field(last);
                return 1'b1;
            end
            PH_FIXED:
            begin
                if (dec_shift > FIXED_SHIFT_MAX)
                    dec_shift = FIXED_SHIFT_MAX;
                dec_acc |= {56'd0, b} << dec_shift;
                dec_shift += FIXED_STEP;
                if (dec_fixed_left != 4'd0)
                    dec_fixed_left = dec_fixed_left - 4'd1;
                if (dec_fixed_left == 4'd0)
                begin
                    r = make_result(KIND_SCALAR, dec_tag, dec_wire, dec_acc, '0, '0, 1'b0, last,
                                    ERR_NONE);
                    next_field(last);
                    return 1'b1;
                end
                if (last)
                begin
                    r = error_token(ERR_TRUNC, dec_tag, dec_wire, last);
                    return 1'b1;
                end
                return 1'b0;
            end
            PH_PAYLOAD:
            begin
                if (dec_pay_left != 32'd0)
                    dec_pay_left = dec_pay_left - 32'd1;
                if (dec_pay_left == 32'd0)
                begin
                    r = make_result(KIND_DATA, dec_tag, dec_wire, '0, '0, b, 1'b1, last,
                                    ERR_NONE);
                    next_field(last);
                    return 1'b1;
                end
                if (last)
                begin
                    r = error_token(ERR_TRUNC, dec_tag, dec_wire, last);
                    return 1'b1;
                end
                r = make_result(KIND_DATA, dec_tag, dec_wire, '0, '0, b, 1'b0, 1'b0, ERR_NONE);
                return 1'b1;
            end
            default:
            begin
                clear_decoder();
                return 1'b0;
            end
        endcase
        return 1'b0;
    endfunction

    function automatic void report_field(input string what, input logic [63:0] want,
            input logic [63:0] got);
        mismatch_count++;
        $display("%0t: %s expected %0h, actual %0h", $time, what, want, got);
    endfunction

    function automatic void check_token(input result_t got);
        result_t want;
        if (pending_tokens.size() == 0)
        begin
            mismatch_count++;
            $display("%0t: token word with none expected, expected nothing, actual kind %0d",
                     $time, got.kind);
            return;
        end
        want = pending_tokens.pop_front();
        if (got.kind <= KIND_ERROR)
            kind_seen[got.kind]++;
        if (got.kind !== want.kind)
            report_field("kind", want.kind, got.kind);
        if (got.field_tag !== want.field_tag)
            report_field("field_tag", want.field_tag, got.field_tag);
        if (got.wire_kind !== want.wire_kind)
            report_field("wire_kind", want.wire_kind, got.wire_kind);
        if (got.raw_value !== want.raw_value)
            report_field("raw_value", want.raw_value, got.raw_value);
        if (got.zigzag_value !== want.zigzag_value)
            report_field("zigzag_value", want.zigzag_value, got.zigzag_value);
        if (got.data_byte !== want.data_byte)
            report_field("data_byte", want.data_byte, got.data_byte);
        if (got.payload_last !== want.payload_last)
            report_field("payload_last", want.payload_last, got.payload_last);
        if (got.msg_end !== want.msg_end)
            report_field("msg_end", want.msg_end, got.msg_end);
        if (got.error_code !== want.error_code)
            report_field("error_code", want.error_code, got.error_code);
    endfunction

    // compare outputs before predicting, all on values from before the edge
    always @(posedge clk)
    begin : monitor
        result_t predicted;
        bit      produced;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
                check_token(make_result(kind, field_tag, wire_kind, raw_value, zigzag_value,
                                        data_byte, payload_last, msg_end, error_code));
            if (in_valid && !in_stall)
            begin
                produced = decode_byte(in_byte, is_last, predicted);
                if (produced)
                    pending_tokens.push_back(predicted);
                if (pin_on)
                begin
                    if (!produced)
                        report_field("directed token present", 64'd1, 64'd0);
                    else
                    begin
                        if (predicted.kind !== pin_kind)
                            report_field("directed kind", pin_kind, predicted.kind);
                        if (predicted.raw_value !== pin_raw)
                            report_field("directed raw_value", pin_raw, predicted.raw_value);
                        if (predicted.error_code !== pin_err)
                            report_field("directed error_code", pin_err, predicted.error_code);
                        if (predicted.msg_end !== pin_end)
                            report_field("directed msg_end", pin_end, predicted.msg_end);
                    end
                end
            end
        end
    end

    // receiver: random stalls, plus one long hold-off on request
    initial
    begin : receiver
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_request = 1'b0;
                hold_count++;
            end
            else
            begin
                out_stall <= ($urandom_range(0, 99) < stall_pct);
            end
        end
    end

    task automatic send_word(input logic [7:0] b, input logic last, input bit pin,
            input logic [2:0] pk, input logic [63:0] praw, input logic [1:0] perr,
            input logic pend);
        @(negedge clk);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_byte  <= b;
        is_last  <= last;
        pin_on   <= pin;
        pin_kind <= pk;
        pin_raw  <= praw;
        pin_err  <= perr;
        pin_end  <= pend;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        words_sent++;
    endtask

    function automatic void add_row(input logic [7:0] b, input logic last, input bit pin,
            input logic [2:0] k, input logic [63:0] raw, input logic [1:0] err,
            input logic fin);
        stim_row_t row;
        row.b    = b;
        row.last = last;
        row.pin  = pin;
        row.kind = k;
        row.raw  = raw;
        row.err  = err;
        row.fin  = fin;
        stim_rows.push_back(row);
    endfunction

    function automatic void put_varint(input logic [63:0] v);
        do
        begin
            msg_bytes.push_back({(v >> 7) != 64'd0, v[6:0]});
            v = v >> 7;
        end
        while (v != 64'd0);
    endfunction

    // n bytes of random content; all continued, or closed on the last one
    function automatic void put_cont_bytes(input int n, input bit close);
        logic [7:0] b;
        for (int i = 0; i < n; i++)
        begin
            b    = 8'($urandom);
            b[7] = !(close && i == n - 1);
            msg_bytes.push_back(b);
        end
    endfunction

    function automatic logic [28:0] pick_tag();
        logic [28:0] t;
        t = 29'($urandom);
        case ($urandom_range(0, 3))
            0:       t = 29'd1;
            1:       t = '1;
            2:       t = 29'($urandom_range(1, 15));
            default: t = t >> $urandom_range(0, 28);
        endcase
        return t;
    endfunction

    function automatic logic [63:0] pick_value();
        logic [63:0] v;
        v = {$urandom, $urandom};
        case ($urandom_range(0, 5))
            0:       v = '0;
            1:       v = '1;
            2:       v = 64'd1 << $urandom_range(0, 63);
            3:       v = v >> $urandom_range(0, 63);
            4:       v = v & 64'h7F;
            default: ;
        endcase
        return v;
    endfunction

    function automatic void put_field();
        logic [28:0] tag;
        logic [2:0]  wt;
        logic [63:0] v;
        int          n;
        tag = pick_tag();
        case ($urandom_range(0, 3))
            0:       wt = WT_VARINT;
            1:       wt = WT_FIXED64;
            2:       wt = WT_LEN;
            default: wt = WT_FIXED32;
        endcase
        put_varint({32'd0, tag, wt});
        v = pick_value();
        case (wt)
            WT_VARINT:
                if ($urandom_range(0, 3) == 0)
                    put_cont_bytes($urandom_range(1, 10), 1'b1);
                else
                    put_varint(v);
            WT_FIXED64:
                for (int i = 0; i < 8; i++)
                    msg_bytes.push_back(v[8*i +: 8]);
            WT_FIXED32:
                for (int i = 0; i < 4; i++)
                    msg_bytes.push_back(v[8*i +: 8]);
            default:
            begin
                n = ($urandom_range(0, 15) == 0) ? $urandom_range(7, 40) : $urandom_range(0, 4);
                put_varint(64'(n));
                for (int i = 0; i < n; i++)
                    msg_bytes.push_back(8'($urandom));
            end
        endcase
    endfunction

    // mostly well-formed messages; some truncated or broken on purpose
    function automatic void build_message();
        int         cut;
        logic [2:0] bad_wt;
        msg_bytes.delete();
        repeat ($urandom_range(1, 4))
            put_field();
        case ($urandom_range(0, 15))
            0:
            begin
                cut = $urandom_range(1, msg_bytes.size());
                while (msg_bytes.size() > cut)
                    msg_bytes.delete(msg_bytes.size() - 1);
            end
            1:
            begin
                bad_wt = 3'($urandom);
                while (bad_wt == WT_VARINT || bad_wt == WT_FIXED64 || bad_wt == WT_LEN ||
                       bad_wt == WT_FIXED32)
                    bad_wt = 3'($urandom);
                put_varint({32'd0, pick_tag(), bad_wt});
                put_cont_bytes($urandom_range(1, 3), 1'b1);
            end
            2: put_cont_bytes($urandom_range(5, 7), 1'b0);
            3:
            begin
                put_varint({32'd0, pick_tag(), WT_VARINT});
                put_cont_bytes($urandom_range(10, 12), 1'b0);
            end
            4:
            begin
                put_varint({32'd0, pick_tag(), WT_LEN});
                put_cont_bytes($urandom_range(5, 6), 1'b0);
            end
            5:
            begin
                if ($urandom_range(0, 1))
                    msg_bytes.push_back(8'h00);
                else
                begin
                    msg_bytes.push_back(8'h80);
                    msg_bytes.push_back(8'h00);
                end
                put_field();
            end
            6:
            begin
                // over-long key or plain garbage
                put_cont_bytes($urandom_range(1, 5), 1'b1);
                repeat ($urandom_range(0, 8))
                    msg_bytes.push_back(8'($urandom));
            end
            7:
            begin
                // huge length, message ends inside the payload
                put_varint({32'd0, pick_tag(), WT_LEN});
                put_varint(64'hFFFF_FFFF >> $urandom_range(0, 31));
                repeat ($urandom_range(0, 3))
                    msg_bytes.push_back(8'($urandom));
            end
            default: ;
        endcase
    endfunction

    task automatic send_message();
        for (int i = 0; i < msg_bytes.size(); i++)
            send_word(msg_bytes[i], i == msg_bytes.size() - 1, 1'b0, KIND_SCALAR, '0,
                      ERR_NONE, 1'b0);
        msgs_sent++;
    endtask

    initial
    begin : main
        int target;
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        in_byte        = '0;
        is_last        = 1'b0;
        out_stall      = 1'b0;
        pin_on         = 1'b0;
        pin_kind       = KIND_SCALAR;
        pin_raw        = '0;
        pin_err        = ERR_NONE;
        pin_end        = 1'b0;
        hold_request   = 1'b0;
        hold_count     = 0;
        send_idle_pct  = 0;
        stall_pct      = 0;
        words_sent     = 0;
        msgs_sent      = 0;
        mismatch_count = 0;
        foreach (kind_seen[i])
            kind_seen[i] = 0;
        clear_decoder();
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // zero key as the whole message
        add_row(8'h00, 1'b1, 1'b1, KIND_END, '0, ERR_NONE, 1'b1);
        // tag 2 bytes field, one payload byte
        add_row(8'h12, 1'b0, 1'b0, KIND_SCALAR, '0, ERR_NONE, 1'b0);
        add_row(8'h01, 1'b0, 1'b1, KIND_HEADER, 64'd1, ERR_NONE, 1'b0);
        add_row(8'h41, 1'b1, 1'b0, KIND_SCALAR, '0, ERR_NONE, 1'b0);
        // wire type 3, then the rest is skipped
        add_row(8'h0B, 1'b0, 1'b1, KIND_ERROR, '0, ERR_WIRE, 1'b0);
        add_row(8'h55, 1'b1, 1'b0, KIND_SCALAR, '0, ERR_NONE, 1'b0);
        // key still continued on its fifth byte
        repeat (4)
            add_row(8'hFF, 1'b0, 1'b0, KIND_SCALAR, '0, ERR_NONE, 1'b0);
        add_row(8'hFF, 1'b1, 1'b1, KIND_ERROR, '0, ERR_OVERFLOW, 1'b1);
        // message ends right after a key
        add_row(8'h08, 1'b1, 1'b1, KIND_ERROR, '0, ERR_TRUNC, 1'b1);
        // zero key in two-byte form, trailing byte skipped
        add_row(8'h80, 1'b0, 1'b0, KIND_SCALAR, '0, ERR_NONE, 1'b0);
        add_row(8'h00, 1'b0, 1'b1, KIND_END, '0, ERR_NONE, 1'b1);
        add_row(8'h01, 1'b1, 1'b0, KIND_SCALAR, '0, ERR_NONE, 1'b0);
        // varint value still continued on its tenth byte
        add_row(8'h08, 1'b0, 1'b0, KIND_SCALAR, '0, ERR_NONE, 1'b0);
        repeat (9)
            add_row(8'hFF, 1'b0, 1'b0, KIND_SCALAR, '0, ERR_NONE, 1'b0);
        add_row(8'hFF, 1'b1, 1'b1, KIND_ERROR, '0, ERR_OVERFLOW, 1'b1);

        foreach (stim_rows[i])
            send_word(stim_rows[i].b, stim_rows[i].last, stim_rows[i].pin, stim_rows[i].kind,
                      stim_rows[i].raw, stim_rows[i].err, stim_rows[i].fin);

        for (int phase_idx = 0; phase_idx < 4; phase_idx++)
        begin
            case (phase_idx)
                0:
                begin
                    send_idle_pct = 0;
                    stall_pct     = 0;
                    hold_request  = 1'b1;
                end
                1:
                begin
                    send_idle_pct = 51;
                    stall_pct     = 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    stall_pct     = 51;
                end
                default:
                begin
                    send_idle_pct = 6;
                    stall_pct     = 6;
                end
            endcase
            target = words_sent + RANDOM_WORDS / 4;
            while (words_sent < target)
            begin
                build_message();
                send_message();
            end
        end
        @(negedge clk);
        in_valid <= 1'b0;

        while (pending_tokens.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d bytes: %0d directed, then %0d random messages over four idle mixes,",
                 words_sent, stim_rows.size(), msgs_sent);
        $display("hold-offs %0d; words: %0d scalar, %0d header, %0d data, %0d end, %0d error",
                 hold_count, kind_seen[KIND_SCALAR], kind_seen[KIND_HEADER],
                 kind_seen[KIND_DATA], kind_seen[KIND_END], kind_seen[KIND_ERROR]);
        if (mismatch_count == 0 && pending_tokens.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin : watchdog
        #5_000_000;
        $display("%0t: timed out with %0d token words outstanding", $time, pending_tokens.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/core/pwtp_pkg.sv
rtl/core/pwtp_decode.sv
rtl/core/protobuf_wire_token_parser.sv
verif/testbench.sv
